[design/triangle_kernel_line_blur_core_assert.svh]
// Assertion macros used by the blur core
`ifndef TRIANGLE_KERNEL_LINE_BLUR_CORE_ASSERT_SVH
`define TRIANGLE_KERNEL_LINE_BLUR_CORE_ASSERT_SVH

// Same-cycle implication
`define TKLB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TKLB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tklb_pkg.sv]
package tklb_pkg;

   localparam int MAX_RADIUS_DEF = 63;
   localparam int RING_DEPTH_DEF = 128;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 24;
   localparam int SUM_W    = 30;
   localparam int RSQ_W    = 12;
   localparam int POS_W    = 8;

   localparam logic [POS_W-1:0] POS_MAX = 8'd255;

   // how the outgoing ring samples enter the first difference
   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SUB,
      MODE_BOTH
   } mode_type;

   typedef struct packed {
      logic     init;
      logic     rd;
      logic     exec;
      logic     cap;
      logic     div_step;
      mode_type mode;
   } lane_ctrl_type;

endpackage

[design/tklb_lane.sv]
module tklb_lane #(
   parameter int RING_DEPTH = tklb_pkg::RING_DEPTH_DEF,
   localparam int PW = $clog2(RING_DEPTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tklb_pkg::lane_ctrl_type         ctrl,
   input  logic [tklb_pkg::RSQ_W-1:0]      rsq,
   input  logic                            wide,
   input  logic [tklb_pkg::SAMPLE_W-1:0]   pixel,
   input  logic [PW-1:0]                   rd_back,
   input  logic [PW-1:0]                   rd_ix,
   input  logic [PW-1:0]                   wr_addr,
   output logic [tklb_pkg::SAMPLE_W-1:0]   q
);

   logic [tklb_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
   logic [tklb_pkg::SAMPLE_W-1:0] back_ff, ix_ff;
   logic [tklb_pkg::DIFF_W-1:0]   diff_ff, diff_in;
   logic [tklb_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [tklb_pkg::SUM_W-1:0]    num_ff, num_in;
   logic [tklb_pkg::RSQ_W-1:0]    rem_ff, rem_in;
   logic [tklb_pkg::DIFF_W-1:0]   d_acc;
   logic [tklb_pkg::RSQ_W:0]      trial;
   logic                          ge;
   logic [tklb_pkg::SAMPLE_W-1:0] lim;

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         ring[wr_addr] <= pixel;
      end
      if (ctrl.rd) begin
         back_ff <= ring[rd_back];
         ix_ff   <= ring[rd_ix];
      end
   end

   always_comb begin
      d_acc = diff_ff;
      unique case (ctrl.mode)
         tklb_pkg::MODE_BOTH: d_acc = diff_ff + tklb_pkg::DIFF_W'(back_ff)
                                      - {7'd0, ix_ff, 1'b0};
         tklb_pkg::MODE_SUB:  d_acc = diff_ff - {7'd0, ix_ff, 1'b0};
         tklb_pkg::MODE_NONE: d_acc = diff_ff;
         default:             d_acc = diff_ff;
      endcase
      diff_in = d_acc + tklb_pkg::DIFF_W'(pixel);
      sum_in  = sum_ff + {{(tklb_pkg::SUM_W-tklb_pkg::DIFF_W){diff_in[tklb_pkg::DIFF_W-1]}},
                          diff_in};
   end

   // restoring division, one quotient bit a cycle; num_ff ends up as the quotient
   always_comb begin
      trial  = {rem_ff, num_ff[tklb_pkg::SUM_W-1]};
      ge     = trial >= {1'b0, rsq};
      rem_in = ge ? tklb_pkg::RSQ_W'(trial - {1'b0, rsq}) : trial[tklb_pkg::RSQ_W-1:0];
      num_in = {num_ff[tklb_pkg::SUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= '0;
         sum_ff  <= '0;
      end else if (ctrl.init) begin
         diff_ff <= '0;
         sum_ff  <= tklb_pkg::SUM_W'(rsq >> 1);
      end else if (ctrl.exec) begin
         diff_ff <= diff_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap) begin
         // negative sum only after wraparound: result 0
         num_ff <= sum_ff[tklb_pkg::SUM_W-1] ? '0 : sum_ff;
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign lim = wide ? 16'hFFFF : 16'h00FF;
   assign q   = (num_ff > tklb_pkg::SUM_W'(lim)) ? lim : num_ff[tklb_pkg::SAMPLE_W-1:0];

endmodule

[design/tklb_merge.sv]
module tklb_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [tklb_pkg::SAMPLE_W-1:0] red,
   input  logic [tklb_pkg::SAMPLE_W-1:0] green,
   input  logic [tklb_pkg::SAMPLE_W-1:0] blue,
   input  logic                          last,
   output logic                          free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,
   output logic                          rsp_tlast
);

   logic        valid_ff;
   logic [47:0] data_ff;
   logic        last_ff;

   assign free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && free) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         data_ff <= {blue, green, red};
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

[design/triangle_kernel_line_blur_core.sv]
// Triangle-kernel line blur: one RGB pixel per beat, tlast on the last pixel of a line; a line
// of W pixels gives W blurred beats, lagging the input by radius pixels. Each kernel step is a
// registered ring read (RD), then an update (EX). A step that yields a result adds a bit-serial
// divide by radius squared (DIV) and a hand-off of the beat to the result register (PUSH), which
// waits while that register is full. Every beat also passes through acceptance (IDLE) and line
// setup (PREP). The first pixel of a line runs radius+1 steps without results; a pixel with
// tlast runs radius more. The three colour lanes run in parallel; the result register lets the
// next pixel in while a beat waits on rsp_tready. Registers: radius at 0x0, wide_samples at 0x4.
module triangle_kernel_line_blur_core #(
   parameter int MAX_RADIUS = tklb_pkg::MAX_RADIUS_DEF,
   parameter int RING_DEPTH = tklb_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "triangle_kernel_line_blur_core_assert.svh"

   localparam int PW = $clog2(RING_DEPTH);
   localparam logic [PW:0] DEPTH = (PW+1)'(RING_DEPTH);
   localparam logic [5:0] RMAX = 6'(MAX_RADIUS);

   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_WIDE   = 1'b1;

   typedef enum logic [2:0] {IDLE, PREP, RD, EX, DIV, PUSH} state_type;

   state_type                     state_ff, state_in;
   logic [5:0]                    radius_ff, wide_ff_unused;
   logic                          wide_ff;
   logic [5:0]                    r_ff, r_eff;
   logic [tklb_pkg::RSQ_W-1:0]    rsq_ff;
   logic [47:0]                   pix_ff;
   logic                          end_ff, init_ff, emit_ff, last_ff;
   logic [tklb_pkg::POS_W-1:0]    lp_ff, lp_in;
   logic [PW-1:0]                 ptr_ff;
   logic [6:0]                    left_ff;
   logic [4:0]                    cnt_ff;
   logic                          csr_wr;
   logic                          accept;
   logic [PW:0]                   r_ext, back_w, fwd_w, ptr_next;
   logic [PW-1:0]                 rd_back, wr_addr;
   tklb_pkg::lane_ctrl_type       ctrl;
   logic [tklb_pkg::SAMPLE_W-1:0] q_r, q_g, q_b;
   logic                          out_free, load;
   logic                          ge2r, ger;

   assign wide_ff_unused = '0;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 6'd1;
         wide_ff   <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_RADIUS: radius_ff <= csr_pwdata[5:0];
            REG_WIDE:   wide_ff   <= csr_pwdata[0];
            default:    radius_ff <= radius_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RADIUS: csr_prdata = {26'd0, radius_ff};
         REG_WIDE:   csr_prdata = {31'd0, wide_ff} | {26'd0, wide_ff_unused};
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      r_eff = radius_ff;
      if (r_eff == 6'd0) r_eff = 6'd1;
      if (r_eff > RMAX)  r_eff = RMAX;
   end

   // ring addresses
   always_comb begin
      r_ext    = (PW+1)'(r_ff);
      back_w   = ({1'b0, ptr_ff} >= r_ext) ? {1'b0, ptr_ff} - r_ext
                                            : {1'b0, ptr_ff} + DEPTH - r_ext;
      fwd_w    = {1'b0, ptr_ff} + r_ext;
      if (fwd_w >= DEPTH) fwd_w = fwd_w - DEPTH;
      ptr_next = {1'b0, ptr_ff} + (PW+1)'(1);
      if (ptr_next == DEPTH) ptr_next = '0;
      rd_back  = back_w[PW-1:0];
      wr_addr  = fwd_w[PW-1:0];
   end

   assign ge2r = lp_ff >= {1'b0, r_ff, 1'b0};
   assign ger  = lp_ff >= {2'b00, r_ff};

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == PUSH);

   always_comb begin
      ctrl          = '0;
      ctrl.init     = (state_ff == PREP) && init_ff;
      ctrl.rd       = (state_ff == RD);
      ctrl.exec     = (state_ff == EX);
      ctrl.cap      = (state_ff == EX) && ge2r;
      ctrl.div_step = (state_ff == DIV);
      ctrl.mode     = ge2r ? tklb_pkg::MODE_BOTH
                    : (ger ? tklb_pkg::MODE_SUB : tklb_pkg::MODE_NONE);
   end

   always_comb begin
      lp_in = (lp_ff < tklb_pkg::POS_MAX) ? lp_ff + 8'd1 : lp_ff;
      if (end_ff && left_ff == 7'd1) lp_in = '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: if (accept) state_in = PREP;
         PREP: state_in = RD;
         RD:   state_in = EX;
         EX:   state_in = ge2r ? DIV : ((left_ff == 7'd1) ? IDLE : RD);
         DIV:  if (cnt_ff == 5'(tklb_pkg::SUM_W - 1)) state_in = PUSH;
         PUSH: if (out_free) state_in = (left_ff == 7'd0) ? IDLE : RD;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         lp_ff    <= '0;
         ptr_ff   <= '0;
         left_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            left_ff <= ((lp_ff == '0) ? 7'(r_eff) + 7'd1 : 7'd1)
                     + (req_tlast ? 7'(r_eff) : 7'd0);
         end
         if (state_ff == EX) begin
            lp_ff   <= lp_in;
            ptr_ff  <= ptr_next[PW-1:0];
            left_ff <= left_ff - 7'd1;
         end
         cnt_ff <= (state_ff == DIV) ? cnt_ff + 5'd1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_tdata;
         end_ff  <= req_tlast;
         init_ff <= (lp_ff == '0);
         r_ff    <= r_eff;
         rsq_ff  <= tklb_pkg::RSQ_W'(r_eff) * tklb_pkg::RSQ_W'(r_eff);
      end
      if (state_ff == EX) begin
         emit_ff <= ge2r;
         last_ff <= end_ff && (left_ff == 7'd1);
      end
   end

   tklb_lane #(.RING_DEPTH(RING_DEPTH)) u_red (
      .clock, .reset, .ctrl, .rsq(rsq_ff), .wide(wide_ff), .pixel(pix_ff[15:0]),
      .rd_back, .rd_ix(ptr_ff), .wr_addr, .q(q_r)
   );

   tklb_lane #(.RING_DEPTH(RING_DEPTH)) u_green (
      .clock, .reset, .ctrl, .rsq(rsq_ff), .wide(wide_ff), .pixel(pix_ff[31:16]),
      .rd_back, .rd_ix(ptr_ff), .wr_addr, .q(q_g)
   );

   tklb_lane #(.RING_DEPTH(RING_DEPTH)) u_blue (
      .clock, .reset, .ctrl, .rsq(rsq_ff), .wide(wide_ff), .pixel(pix_ff[47:32]),
      .rd_back, .rd_ix(ptr_ff), .wr_addr, .q(q_b)
   );

   tklb_merge u_merge (
      .clock, .reset, .load, .red(q_r), .green(q_g), .blue(q_b), .last(last_ff),
      .free(out_free), .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   `TKLB_ASSERT_NOW(a_idle_done, req_tready, left_ff == 7'd0, "pixel taken with steps pending")
   `TKLB_ASSERT_NOW(a_push_emit, state_ff == PUSH, emit_ff, "result pushed without emission")
   `TKLB_ASSERT_NEXT(a_line_reset, (state_ff == EX) && end_ff && (left_ff == 7'd1),
      lp_ff == '0, "line position not cleared at line end")

endmodule

[tb/sv/triangle_kernel_line_blur_checker.sv]
module triangle_kernel_line_blur_checker #(
   parameter logic [2:0] ADDR_RADIUS = 3'h0,
   parameter logic [2:0] ADDR_WIDE   = 3'h4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32]
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // red_out[15:0], green_out[31:16], blue_out[47:32]
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = tklb_pkg::RING_DEPTH_DEF;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        line_end;
   } blur_pixel_type;

   blur_pixel_type blurred_q[$];

   logic [5:0]         radius_reg;
   logic               wide_reg;
   logic [15:0]        sample_ring [3][RING];
   logic signed [23:0] first_diff [3];
   logic signed [29:0] run_sum [3];
   logic [7:0]         line_pos;
   logic [6:0]         ring_ptr;

   task automatic report(input string what);
      $display("[%0t] blur mismatch: %s", $time, what);
      errors++;
   endtask

   function automatic logic [15:0] scaled(input logic signed [29:0] s, input int r);
      longint q;
      if (s <= 0) return 16'd0;
      q = longint'(s) / (r * r);
      if (wide_reg) return (q > 65535) ? 16'hFFFF : q[15:0];
      return (q > 255) ? 16'd255 : q[15:0];
   endfunction

   task automatic kernel_step(input logic [15:0] px [3], input int r, input logic mark_end);
      blur_pixel_type res;
      longint d;
      int ix, back, fwd;
      ix   = ring_ptr;
      back = (ring_ptr + RING - r) % RING;
      fwd  = (ring_ptr + r) % RING;
      if (line_pos >= 2 * r) begin
         res.red      = scaled(run_sum[0], r);
         res.green    = scaled(run_sum[1], r);
         res.blue     = scaled(run_sum[2], r);
         res.line_end = mark_end;
         blurred_q.push_back(res);
      end
      for (int ch = 0; ch < 3; ch++) begin
         d = longint'(first_diff[ch]);
         if (line_pos >= 2 * r)
            d += longint'(sample_ring[ch][back]) - 2 * longint'(sample_ring[ch][ix]);
         else if (line_pos >= r)
            d -= 2 * longint'(sample_ring[ch][ix]);
         d += px[ch];
         first_diff[ch] = d[23:0];
         run_sum[ch] = run_sum[ch] + first_diff[ch];
         sample_ring[ch][fwd] = px[ch];
      end
      ring_ptr = ring_ptr + 7'd1;
      if (line_pos != 8'd255) line_pos = line_pos + 8'd1;
   endtask

   task automatic accept_pixel(input logic [47:0] data, input logic last);
      logic [15:0] px [3];
      int r;
      px[0] = data[15:0];
      px[1] = data[31:16];
      px[2] = data[47:32];
      r = (radius_reg == 6'd0) ? 1 : int'(radius_reg);
      if (line_pos == 8'd0) begin
         for (int ch = 0; ch < 3; ch++) begin
            first_diff[ch] = '0;
            run_sum[ch] = 30'((r * r) >> 1);
         end
         for (int k = 0; k <= r; k++) kernel_step(px, r, 1'b0);
      end else begin
         kernel_step(px, r, 1'b0);
      end
      if (last) begin
         for (int k = 0; k < r; k++) kernel_step(px, r, k + 1 == r);
         line_pos = 8'd0;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      blur_pixel_type want;
      if (reset) begin
         blurred_q.delete();
         radius_reg = 6'd1;
         wide_reg = 1'b0;
         foreach (sample_ring[ch, i]) sample_ring[ch][i] = '0;
         for (int ch = 0; ch < 3; ch++) begin
            first_diff[ch] = '0;
            run_sum[ch] = '0;
         end
         line_pos = '0;
         ring_ptr = '0;
      end else begin
         // check the outgoing beat first: it can only stem from earlier input
         if (rsp_tvalid && rsp_tready) begin
            if (blurred_q.size() == 0) begin
               report($sformatf("beat %h/%b with nothing expected", rsp_tdata, rsp_tlast));
            end else begin
               want = blurred_q.pop_front();
               if (rsp_tdata[15:0] !== want.red)
                  report($sformatf("red %h, want %h", rsp_tdata[15:0], want.red));
               if (rsp_tdata[31:16] !== want.green)
                  report($sformatf("green %h, want %h", rsp_tdata[31:16], want.green));
               if (rsp_tdata[47:32] !== want.blue)
                  report($sformatf("blue %h, want %h", rsp_tdata[47:32], want.blue));
               if (rsp_tlast !== want.line_end)
                  report($sformatf("line end %b, want %b", rsp_tlast, want.line_end));
            end
         end
         if (req_tvalid && req_tready) accept_pixel(req_tdata, req_tlast);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_RADIUS: radius_reg = csr_pwdata[5:0];
               ADDR_WIDE:   wide_reg = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      pending = blurred_q.size();
   end

endmodule

[tb/sv/triangle_kernel_line_blur_core_tb.sv]
module triangle_kernel_line_blur_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_RADIUS = 3'h0;
   localparam logic [2:0] ADDR_WIDE   = 3'h4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int errors;
   int pending;
   int req_idle_pct;
   int rsp_stall_pct;
   int hold_left;

   triangle_kernel_line_blur_core u_dut (.*);

   triangle_kernel_line_blur_checker #(
      .ADDR_RADIUS(ADDR_RADIUS),
      .ADDR_WIDE  (ADDR_WIDE)
   ) u_checker (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      #24_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge; tvalid stays high after the beat
   task automatic send_pixel(input logic [15:0] r, g, b, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_line(input int len);
      for (int i = 0; i < len; i++)
         send_pixel(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // let every expected beat out, then a margin for the tail of the flush
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic pick_setup();
      int pick;
      pick = $urandom_range(9);
      if (pick < 7) csr_write(ADDR_RADIUS, $urandom_range(6, 1));
      else if (pick < 9) csr_write(ADDR_RADIUS, $urandom_range(20, 7));
      else csr_write(ADDR_RADIUS, 63);
      csr_write(ADDR_WIDE, $urandom_range(1));
   endtask

   task automatic run_phase(input int tx_idle, input int rx_stall, input int n_items,
                            input bit with_hold);
      int sent;
      req_idle_pct  = tx_idle;
      rsp_stall_pct = rx_stall;
      sent = 0;
      drain();
      pick_setup();
      if (with_hold) hold_left = 600;
      while (sent < n_items) begin
         int len;
         len = $urandom_range(12, 1);
         send_line(len);
         sent += len;
         if ($urandom_range(2) == 0) begin
            drain();
            pick_setup();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset radius, narrow: full-scale input clamps to 255
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
      drain();
      // radius 0 behaves as 1
      csr_write(ADDR_RADIUS, 0);
      send_pixel(16'h0000, 16'hFFFF, 16'h8000, 1'b0);
      send_pixel(16'hFFFF, 16'h0000, 16'h00FF, 1'b0);
      send_pixel(16'h8000, 16'h1234, 16'hFFFF, 1'b1);
      drain();
      // largest radius, wide samples
      csr_write(ADDR_RADIUS, 63);
      csr_write(ADDR_WIDE, 1);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_pixel(16'h0000, 16'hFFFF, 16'h0001, 1'b1);
      drain();
      csr_write(ADDR_RADIUS, 5);
      for (int i = 0; i < 8; i++)
         send_pixel((i % 2) ? 16'hFFFF : 16'h0000, 16'h00FF << (i % 9),
                    16'hFFFF - 16'(i), i == 7);
      drain();
      csr_write(ADDR_WIDE, 0);
      send_pixel(16'hFFFF, 16'h0100, 16'h0000, 1'b0);
      send_pixel(16'hFFFF, 16'h0100, 16'h0000, 1'b1);

      run_phase(0, 0, 6, 1'b0);
      run_phase(76, 0, 6, 1'b0);
      run_phase(0, 76, 6, 1'b1);
      run_phase(19, 19, 6, 1'b0);

      // long line so the step count saturates
      req_idle_pct = 0;
      rsp_stall_pct = 19;
      drain();
      csr_write(ADDR_RADIUS, 63);
      csr_write(ADDR_WIDE, 1);
      send_line(130);

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
